### rtl/l3d_pkg.sv
package l3d_pkg;

    localparam int ENTRY_W = 13;
    localparam int PIX_W   = 8;
    localparam int IDX_W   = 6;
    localparam int GRID_W  = 6;
    localparam int WORD_W  = 3 * ENTRY_W;
    localparam int DATA_W  = 32;

    localparam logic [GRID_W-1:0] GRID_RESET = 6'd33;

    typedef enum logic
    {
        OP_LOAD  = 1'b0,
        OP_PIXEL = 1'b1
    } op_t;

    typedef enum logic
    {
        REG_GRID_POINTS = 1'b0,
        REG_NONE        = 1'b1
    } reg_idx_t;

    typedef struct packed
    {
        logic [23:0] q;
        logic [7:0]  r;
    } div255_t;

    // x / 255 for x below 255 * 255 * 256: x * 257 >> 16 is low by at most one
    function automatic div255_t div255(input logic [23:0] x);
        div255_t     res;
        logic [32:0] p;
        logic [23:0] qa;
        logic [24:0] r;
        p  = {9'd0, x} * 33'd257;
        qa = {7'd0, p[32:16]};
        r  = {1'b0, x} - ({1'b0, qa} * 25'd255);
        if (r >= 25'd255)
        begin
            res.q = qa + 24'd1;
            res.r = 8'(r - 25'd255);
        end
        else
        begin
            res.q = qa;
            res.r = r[7:0];
        end
        return res;
    endfunction

endpackage

### rtl/l3d_bank.sv
module l3d_bank #(
    parameter int DEPTH = 4913,
    parameter int AW    = 13,
    parameter int W     = 39
) (
    input  logic          clk,
    input  logic          en,
    input  logic          we,
    input  logic [AW-1:0] addr,
    input  logic [W-1:0]  wdata,
    output logic [W-1:0]  rdata
);

    logic [W-1:0] mem [DEPTH];
    logic [W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/lut3d_trilinear_color_map.sv
// channel | direction | handshake               | payload
// in      | input     | in_valid / in_ready     | op, indexes, entry_*, pixel_*
// out     | output    | out_valid / out_ready   | mapped_red/green/blue
// cfg     | input     | psel, penable, pwrite   | paddr, pwdata, prdata
// One item per clock unless stalled; pixel results pass p0 to p8 and out_res_reg.
// The table sits in eight one-port banks split by index parity, so all eight
// corners of a cell are read in one cycle; an in-range load writes one bank.
// Loads give no result. The pipeline stalls only when its last stage is full and
// the output register holds an untaken result. Reset clears valid bits and
// grid_points (33); table contents are undefined until written.
module lut3d_trilinear_color_map #(
    parameter int MAX_GRID        = 33,
    parameter int ENTRY_FRAC_BITS = 12
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          op,
    input  logic [l3d_pkg::IDX_W-1:0]     red_index,
    input  logic [l3d_pkg::IDX_W-1:0]     green_index,
    input  logic [l3d_pkg::IDX_W-1:0]     blue_index,
    input  logic [l3d_pkg::ENTRY_W-1:0]   entry_red,
    input  logic [l3d_pkg::ENTRY_W-1:0]   entry_green,
    input  logic [l3d_pkg::ENTRY_W-1:0]   entry_blue,
    input  logic [l3d_pkg::PIX_W-1:0]     pixel_red,
    input  logic [l3d_pkg::PIX_W-1:0]     pixel_green,
    input  logic [l3d_pkg::PIX_W-1:0]     pixel_blue,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [l3d_pkg::PIX_W-1:0]     mapped_red,
    output logic [l3d_pkg::PIX_W-1:0]     mapped_green,
    output logic [l3d_pkg::PIX_W-1:0]     mapped_blue,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [l3d_pkg::DATA_W-1:0]    pwdata,
    output logic [l3d_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);

    localparam int IW    = $clog2(MAX_GRID);
    localparam int HW    = $clog2(MAX_GRID + 1);
    localparam int HALF  = MAX_GRID / 2 + 1;
    localparam int HIW   = $clog2(HALF);
    localparam int DEPTH = HALF * HALF * HALF;
    localparam int AW    = $clog2(DEPTH);
    localparam int EW    = l3d_pkg::ENTRY_W;
    localparam int WW    = l3d_pkg::WORD_W;
    localparam logic [39:0] HALF_D = 40'd65025 << (ENTRY_FRAC_BITS - 1);
    localparam logic [39:0] SAT_X  = 40'd16646400;

    // configuration
    logic [l3d_pkg::GRID_W-1:0] grid_reg;
    logic [6:0]                 n_eff;
    logic [IW-1:0]              nm1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_reg <= l3d_pkg::GRID_RESET;
        end
        else if (psel && penable && pwrite && paddr[2] == l3d_pkg::REG_GRID_POINTS)
        begin
            grid_reg <= pwdata[l3d_pkg::GRID_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == l3d_pkg::REG_GRID_POINTS) ?
                    {{(l3d_pkg::DATA_W - l3d_pkg::GRID_W){1'b0}}, grid_reg} : '0;

    always_comb
    begin
        if (grid_reg < 6'd2)
        begin
            n_eff = 7'd2;
        end
        else if ({1'b0, grid_reg} > 7'(MAX_GRID))
        begin
            n_eff = 7'(MAX_GRID);
        end
        else
        begin
            n_eff = {1'b0, grid_reg};
        end
        nm1 = IW'(n_eff - 7'd1);
    end

    // pipeline control
    logic adv;
    logic out_free;
    logic p8_vld_reg;
    logic out_vld_reg;

    assign out_free = !out_vld_reg || out_ready;
    assign adv      = !p8_vld_reg || out_free;
    assign in_ready = adv;

    // p0: request register
    logic                p0_vld_reg;
    logic                p0_op_reg;
    logic [l3d_pkg::IDX_W-1:0] p0_idx_reg [3];
    logic [WW-1:0]       p0_entry_reg;
    logic [7:0]          p0_pix_reg [3];

    // p1: grid position
    logic                p1_vld_reg;
    logic                p1_op_reg;
    logic [l3d_pkg::IDX_W-1:0] p1_idx_reg [3];
    logic [WW-1:0]       p1_entry_reg;
    logic [IW-1:0]       p1_lo_reg [3];
    logic [7:0]          p1_w_reg [3];
    logic [IW-1:0]       p1_lo_next [3];
    logic [7:0]          p1_w_next [3];

    always_comb
    begin
        l3d_pkg::div255_t dv;
        for (int a = 0; a < 3; a++)
        begin
            dv = l3d_pkg::div255(24'(p0_pix_reg[a]) * 24'(nm1));
            p1_lo_next[a] = IW'(dv.q);
            p1_w_next[a]  = dv.r;
        end
    end

    // bank access
    logic          bank_we [8];
    logic [AW-1:0] bank_addr [8];
    logic [WW-1:0] bank_rd [8];

    always_comb
    begin
        logic          p;
        logic [HW-1:0] ax;
        logic [HIW-1:0] hf [3];
        logic          match;
        logic          in_range;
        in_range = 1'b1;
        for (int a = 0; a < 3; a++)
        begin
            if ({1'b0, p1_idx_reg[a]} >= 7'(MAX_GRID))
            begin
                in_range = 1'b0;
            end
        end
        for (int b = 0; b < 8; b++)
        begin
            match = 1'b1;
            for (int a = 0; a < 3; a++)
            begin
                p = 1'((b >> (2 - a)) & 1);
                if (p1_op_reg == l3d_pkg::OP_PIXEL)
                begin
                    ax = (p1_lo_reg[a][0] == p) ? HW'(p1_lo_reg[a]) :
                         HW'(p1_lo_reg[a]) + HW'(1);
                end
                else
                begin
                    ax = HW'(p1_idx_reg[a]);
                end
                if (ax[0] != p)
                begin
                    match = 1'b0;
                end
                hf[a] = HIW'(ax >> 1);
            end
            bank_addr[b] = AW'((AW'(hf[0]) * AW'(HALF) + AW'(hf[1])) * AW'(HALF)
                               + AW'(hf[2]));
            bank_we[b]   = adv && p1_vld_reg && p1_op_reg == l3d_pkg::OP_LOAD &&
                           in_range && match;
        end
    end

    for (genvar g = 0; g < 8; g++)
    begin : g_bank
        l3d_bank #(
            .DEPTH (DEPTH),
            .AW    (AW),
            .W     (WW)
        ) u_bank (
            .clk   (clk),
            .en    (adv),
            .we    (bank_we[g]),
            .addr  (bank_addr[g]),
            .wdata (p1_entry_reg),
            .rdata (bank_rd[g])
        );
    end

    // p2: pixel at bank read, partial weights
    logic        p2_vld_reg;
    logic [2:0]  p2_lopar_reg;
    logic [2:0]  p2_upok_reg;
    logic [15:0] p2_wrg_reg [4];
    logic [7:0]  p2_wb_reg [2];

    // p3: corner data and weight
    logic        p3_vld_reg;
    logic [WW-1:0] p3_data_reg [8];
    logic [23:0] p3_wt_reg [8];

    // p4: products
    logic        p4_vld_reg;
    logic [36:0] p4_prod_reg [8][3];

    // p5: pair sums
    logic        p5_vld_reg;
    logic [37:0] p5_sum_reg [4][3];

    // p6: rounded, scaled by 1/4096
    logic        p6_vld_reg;
    logic [23:0] p6_x_reg [3];
    logic [2:0]  p6_sat_reg;

    // p7: first /255
    logic        p7_vld_reg;
    logic [15:0] p7_x_reg [3];
    logic [2:0]  p7_sat_reg;

    // p8: result
    logic [7:0]  p8_res_reg [3];

    logic [7:0]  out_res_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p0_vld_reg  <= 1'b0;
            p1_vld_reg  <= 1'b0;
            p2_vld_reg  <= 1'b0;
            p3_vld_reg  <= 1'b0;
            p4_vld_reg  <= 1'b0;
            p5_vld_reg  <= 1'b0;
            p6_vld_reg  <= 1'b0;
            p7_vld_reg  <= 1'b0;
            p8_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                p0_vld_reg <= in_valid;
                p1_vld_reg <= p0_vld_reg;
                p2_vld_reg <= p1_vld_reg && p1_op_reg == l3d_pkg::OP_PIXEL;
                p3_vld_reg <= p2_vld_reg;
                p4_vld_reg <= p3_vld_reg;
                p5_vld_reg <= p4_vld_reg;
                p6_vld_reg <= p5_vld_reg;
                p7_vld_reg <= p6_vld_reg;
                p8_vld_reg <= p7_vld_reg;
            end
            if (out_free)
            begin
                out_vld_reg <= p8_vld_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        logic [39:0] acc;
        logic [39:0] x;
        logic [2:0]  bk;
        logic        gate;
        l3d_pkg::div255_t dq;
        if (adv)
        begin
            p0_op_reg     <= op;
            p0_idx_reg[0] <= red_index;
            p0_idx_reg[1] <= green_index;
            p0_idx_reg[2] <= blue_index;
            p0_entry_reg  <= {entry_red, entry_green, entry_blue};
            p0_pix_reg[0] <= pixel_red;
            p0_pix_reg[1] <= pixel_green;
            p0_pix_reg[2] <= pixel_blue;

            p1_op_reg    <= p0_op_reg;
            p1_entry_reg <= p0_entry_reg;
            for (int a = 0; a < 3; a++)
            begin
                p1_idx_reg[a] <= p0_idx_reg[a];
                p1_lo_reg[a]  <= p1_lo_next[a];
                p1_w_reg[a]   <= p1_w_next[a];
            end

            for (int a = 0; a < 3; a++)
            begin
                p2_lopar_reg[a] <= p1_lo_reg[a][0];
                p2_upok_reg[a]  <= p1_w_reg[a] != 8'd0;
            end
            for (int i = 0; i < 4; i++)
            begin
                p2_wrg_reg[i] <= 16'(i[1] ? p1_w_reg[0] : 8'd255 - p1_w_reg[0]) *
                                 16'(i[0] ? p1_w_reg[1] : 8'd255 - p1_w_reg[1]);
            end
            p2_wb_reg[0] <= 8'd255 - p1_w_reg[2];
            p2_wb_reg[1] <= p1_w_reg[2];

            for (int c = 0; c < 8; c++)
            begin
                bk   = {p2_lopar_reg[0] ^ c[2], p2_lopar_reg[1] ^ c[1],
                        p2_lopar_reg[2] ^ c[0]};
                // upper corner with zero weight may point past the grid
                gate = (c[2] && !p2_upok_reg[0]) || (c[1] && !p2_upok_reg[1]) ||
                       (c[0] && !p2_upok_reg[2]);
                p3_data_reg[c] <= gate ? '0 : bank_rd[bk];
                p3_wt_reg[c]   <= 24'(p2_wrg_reg[c[2:1]]) * 24'(p2_wb_reg[c[0]]);
            end

            for (int c = 0; c < 8; c++)
            begin
                for (int ch = 0; ch < 3; ch++)
                begin
                    p4_prod_reg[c][ch] <= 37'(p3_data_reg[c][(2 - ch) * EW +: EW]) *
                                          37'(p3_wt_reg[c]);
                end
            end

            for (int i = 0; i < 4; i++)
            begin
                for (int ch = 0; ch < 3; ch++)
                begin
                    p5_sum_reg[i][ch] <= 38'(p4_prod_reg[2 * i][ch]) +
                                         38'(p4_prod_reg[2 * i + 1][ch]);
                end
            end

            for (int ch = 0; ch < 3; ch++)
            begin
                acc = 40'(p5_sum_reg[0][ch]) + 40'(p5_sum_reg[1][ch]) +
                      40'(p5_sum_reg[2][ch]) + 40'(p5_sum_reg[3][ch]) + HALF_D;
                x   = acc >> ENTRY_FRAC_BITS;
                p6_x_reg[ch]   <= x[23:0];
                p6_sat_reg[ch] <= x >= SAT_X;
            end

            for (int ch = 0; ch < 3; ch++)
            begin
                dq = l3d_pkg::div255(p6_x_reg[ch]);
                p7_x_reg[ch] <= 16'(dq.q);
            end
            p7_sat_reg <= p6_sat_reg;

            for (int ch = 0; ch < 3; ch++)
            begin
                dq = l3d_pkg::div255({8'd0, p7_x_reg[ch]});
                p8_res_reg[ch] <= p7_sat_reg[ch] ? 8'd255 : 8'(dq.q);
            end
        end
        if (out_free)
        begin
            for (int ch = 0; ch < 3; ch++)
            begin
                out_res_reg[ch] <= p8_res_reg[ch];
            end
        end
    end

    assign out_valid    = out_vld_reg;
    assign mapped_red   = out_res_reg[0];
    assign mapped_green = out_res_reg[1];
    assign mapped_blue  = out_res_reg[2];

`ifndef NO_ASSERTIONS
    a_weight_range: assert property (@(posedge clk) disable iff (!rst_n)
        p1_vld_reg && p1_op_reg == l3d_pkg::OP_PIXEL |->
        p1_w_reg[0] < 8'd255 && p1_w_reg[1] < 8'd255 && p1_w_reg[2] < 8'd255)
        else $error("corner weight out of range");

    a_lo_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
        p1_vld_reg && p1_op_reg == l3d_pkg::OP_PIXEL |->
        p1_lo_reg[0] <= nm1 && p1_lo_reg[1] <= nm1 && p1_lo_reg[2] <= nm1)
        else $error("lower index beyond grid");

    a_load_drops: assert property (@(posedge clk) disable iff (!rst_n)
        adv && p1_vld_reg && p1_op_reg == l3d_pkg::OP_LOAD |=> !p2_vld_reg)
        else $error("load request entered the blend pipeline");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        p8_vld_reg && !adv |=> p8_vld_reg && $stable(p8_res_reg[0]) &&
        $stable(p8_res_reg[1]) && $stable(p8_res_reg[2]))
        else $error("last stage changed while stalled");
`endif

endmodule
